>>> sv/assert_macros.svh
// Assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define MMC_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define MMC_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> sv/mmc_pkg.sv
package mmc_pkg;

	typedef struct packed {
		logic signed [15:0] raw_dx;
		logic signed [15:0] raw_dy;
		logic signed [7:0]  wheel_step;
		logic [19:0]        frame_time_us;
		logic               in_menu;
	} mmc_in_t;

	typedef struct packed {
		logic signed [31:0] out_dx;
		logic signed [31:0] out_dy;
		logic               wheel_up;
		logic               wheel_down;
		logic               x_moved;
		logic               y_moved;
		logic [9:0]         cursor_x;
		logic [9:0]         cursor_y;
	} mmc_out_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ACCEL_GAIN   = 3'd0,
		CFG_ACCEL_CAP    = 3'd1,
		CFG_SMOOTH_VALUE = 3'd2,
		CFG_DECEL_VALUE  = 3'd3,
		CFG_MIRROR       = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SM_OFF,
		SM_ADAPT,
		SM_AVG,
		SM_TIME
	} smooth_mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NOACC,
		ST_ACC1,
		ST_ACC2,
		ST_ACC3,
		ST_DIFF,
		ST_AD_CHK,
		ST_AD_SQ,
		ST_AD_ACC,
		ST_RT_SQ,
		ST_RT_CMP,
		ST_AD_K,
		ST_AD_Q,
		ST_AD_AMT,
		ST_AVG,
		ST_TM_DT,
		ST_TM_DTS,
		ST_TM_SQ,
		ST_TM_ACC,
		ST_TM_RATE,
		ST_TM_AMT,
		ST_BL_MUL,
		ST_BL_ADD,
		ST_OUT
	} state_t;

	localparam int POS_W = 28;

	localparam logic [21:0] MIN_ON      = 22'd6;
	localparam logic [21:0] ADAPT_MAX   = 22'd65529;
	localparam logic [21:0] AVG_MAX     = 22'd65542;
	localparam logic [21:0] NINE_TENTHS = 22'd58982;
	localparam logic [32:0] TEN_Q       = 33'd655360;
	localparam logic [16:0] Q_ONE       = 17'd65536;
	localparam logic [39:0] SMALL_LEN2  = 40'd429497;
	localparam logic [16:0] DT_MAX_US   = 17'd100000;
	// floor(q/10) = (q * RECIP10) >> 23 for q below 2^20
	localparam logic signed [28:0] RECIP10 = 29'sd838861;
	// floor(n/15625) = (n * RECIP_DT) >> 41 for n below 2^27
	localparam logic signed [28:0] RECIP_DT = 29'sd140737489;

	// Negate with saturation of the most negative value
	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
		return r;
	endfunction

endpackage

>>> sv/mouse_motion_conditioner.sv
// With acceleration and smoothing off a request passes ST_NOACC, ST_DIFF and ST_OUT; in
// adaptive mode with acceleration on the path may add a 20-step square root, each step
// a square state (ST_RT_SQ) followed by a compare state (ST_RT_CMP).
// Requests: one at a time, taken only in ST_IDLE; all arithmetic shares one
// 34x29 multiplier under the sequencer, one product per cycle.
// Reset: asynchronous; clears configuration (cap set to 6553600), history; cursor to centre.
module mouse_motion_conditioner import mmc_pkg::*; #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 600
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  mmc_in_t     in_req,
	output logic        out_valid,
	input  logic        out_ready,
	output mmc_out_t    out_rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [POS_W-1:0] X_HI  = POS_W'((SCREEN_WIDTH - 1) * 65536);
	localparam logic [POS_W-1:0] Y_HI  = POS_W'((SCREEN_HEIGHT - 1) * 65536);
	localparam logic [POS_W-1:0] X_RST = POS_W'((SCREEN_WIDTH / 2) * 65536);
	localparam logic [POS_W-1:0] Y_RST = POS_W'((SCREEN_HEIGHT / 2) * 65536);

	// configuration
	logic [21:0] gain_q, smooth_q, decel_q;
	logic [30:0] cap_q;
	logic        mirror_q;

	// history and cursor
	logic signed [31:0] prev_dx_q, prev_dy_q;
	logic [POS_W-1:0]   scr_x_q, scr_y_q;

	// control
	state_t      state_q, state_d;
	logic        ax_q;
	logic [4:0]  bit_q;
	logic        out_valid_q;
	mmc_out_t    out_q;

	// datapath scratch
	logic signed [15:0] rx_q, ry_q;
	logic               wup_q, wdn_q, menu_q;
	logic [19:0]        us_q;
	logic signed [31:0] dx_q, dy_q;
	logic signed [32:0] ddx_q, ddy_q;
	logic signed [62:0] prod_q;
	logic [39:0]        s2_q;
	logic [19:0]        root_q, len_q;
	logic [16:0]        amt_q;
	logic [12:0]        dt_q;

	// shared multiplier operands
	logic signed [33:0] mul_a;
	logic signed [28:0] mul_b;

	smooth_mode_t mode;
	logic         gain_on, decel_on, load_out;
	logic signed [15:0] raw_sel;
	logic signed [16:0] raw_abs;
	logic signed [31:0] d_sel, prev_sel;
	logic signed [32:0] dd_sel, ddx_abs, ddy_abs, ddx_n, ddy_n, avg_x, avg_y;
	logic [19:0]        root_try, root_nxt;
	logic signed [62:0] prod_rnd, blend_q, cap_pos, cap_neg, acc_val;
	logic signed [33:0] bl_sum;
	logic [16:0]        us_clip;
	logic [22:0]        rate;
	logic [19:0]        amt_t;
	logic signed [31:0] ox, oy;
	logic [POS_W-1:0]   nx, ny;
	logic signed [35:0] sx, sy;
	logic               small_mv;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	// mode decode
	always_comb begin
		if (smooth_q <= MIN_ON)
			mode = SM_OFF;
		else if (smooth_q <= ADAPT_MAX)
			mode = SM_ADAPT;
		else if (smooth_q <= AVG_MAX)
			mode = SM_AVG;
		else
			mode = SM_TIME;
	end
	assign gain_on  = gain_q > MIN_ON;
	assign decel_on = decel_q > MIN_ON;

	// axis selection
	assign raw_sel  = ax_q ? ry_q : rx_q;
	assign raw_abs  = raw_sel[15] ? -{raw_sel[15], raw_sel} : {raw_sel[15], raw_sel};
	assign d_sel    = ax_q ? dy_q : dx_q;
	assign prev_sel = ax_q ? prev_dy_q : prev_dx_q;
	assign dd_sel   = ax_q ? ddy_q : ddx_q;

	// differences and averages
	assign ddx_n   = {dx_q[31], dx_q} - {prev_dx_q[31], prev_dx_q};
	assign ddy_n   = {dy_q[31], dy_q} - {prev_dy_q[31], prev_dy_q};
	assign ddx_abs = ddx_q[32] ? -ddx_q : ddx_q;
	assign ddy_abs = ddy_q[32] ? -ddy_q : ddy_q;
	always_comb begin
		logic signed [32:0] s;
		s     = {dx_q[31], dx_q} + {prev_dx_q[31], prev_dx_q};
		avg_x = (s + {32'd0, s[32]}) >>> 1;
		s     = {dy_q[31], dy_q} + {prev_dy_q[31], prev_dy_q};
		avg_y = (s + {32'd0, s[32]}) >>> 1;
	end

	// square root step
	assign root_try = root_q | (20'd1 << bit_q);
	assign root_nxt = (prod_q[39:0] <= s2_q) ? root_try : root_q;

	// blend: trunc(prod / 65536) added to the previous delta
	assign prod_rnd = prod_q + (prod_q[62] ? 63'sd65535 : 63'sd0);
	assign blend_q  = prod_rnd >>> 16;
	assign bl_sum   = {{2{prev_sel[31]}}, prev_sel} + blend_q[33:0];

	// acceleration cap
	assign cap_pos = $signed({32'd0, cap_q});
	assign cap_neg = -cap_pos;
	assign acc_val = (prod_q > cap_pos) ? cap_pos : ((prod_q < cap_neg) ? cap_neg : prod_q);

	// time-based rate
	assign us_clip  = (us_q > {3'd0, DT_MAX_US}) ? DT_MAX_US : us_q[16:0];
	assign small_mv = s2_q < SMALL_LEN2;
	assign rate     = small_mv ? (decel_on ? {1'b0, decel_q} : {smooth_q, 1'b0})
	                           : {1'b0, smooth_q};
	assign amt_t    = prod_q[35:16];

	// mirror and cursor
	assign ox = (mirror_q && !menu_q) ? neg_sat(dx_q) : dx_q;
	assign oy = (mirror_q && !menu_q) ? neg_sat(dy_q) : dy_q;
	assign sx = $signed({8'd0, scr_x_q}) + ($signed({{4{ox[31]}}, ox}) <<< 2);
	assign sy = $signed({8'd0, scr_y_q}) + ($signed({{4{oy[31]}}, oy}) <<< 2);
	always_comb begin
		if (sx < 0)
			nx = '0;
		else if (sx > $signed({8'd0, X_HI}))
			nx = X_HI;
		else
			nx = sx[POS_W-1:0];
		if (sy < 0)
			ny = '0;
		else if (sy > $signed({8'd0, Y_HI}))
			ny = Y_HI;
		else
			ny = sy[POS_W-1:0];
	end

	// sequencer outputs: handshake and multiplier operands
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_ACC1: begin
				mul_a = 34'(raw_sel);
				mul_b = 29'(raw_abs);
			end
			ST_ACC2: begin
				mul_a = $signed(prod_q[33:0]);
				mul_b = $signed({7'd0, gain_q});
			end
			ST_AD_SQ: begin
				mul_a = 34'(dd_sel);
				mul_b = $signed(dd_sel[28:0]);
			end
			ST_RT_SQ: begin
				mul_a = $signed({14'd0, root_try});
				mul_b = $signed({9'd0, root_try});
			end
			ST_AD_K: begin
				mul_a = $signed({14'd0, len_q});
				mul_b = (smooth_q < NINE_TENTHS) ? $signed({7'd0, smooth_q})
				                                 : $signed({7'd0, NINE_TENTHS});
			end
			ST_AD_Q: begin
				mul_a = $signed({14'd0, prod_q[35:16]});
				mul_b = RECIP10;
			end
			ST_TM_DT: begin
				mul_a = $signed({7'd0, us_clip, 10'd0});
				mul_b = RECIP_DT;
			end
			ST_TM_SQ: begin
				mul_a = 34'(d_sel);
				mul_b = $signed(d_sel[28:0]);
			end
			ST_TM_RATE: begin
				mul_a = $signed({21'd0, dt_q});
				mul_b = $signed({6'd0, rate});
			end
			ST_BL_MUL: begin
				mul_a = 34'(dd_sel);
				mul_b = $signed({12'd0, amt_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = gain_on ? ST_ACC1 : ST_NOACC;
			ST_NOACC:   state_d = ST_DIFF;
			ST_ACC1:    state_d = ST_ACC2;
			ST_ACC2:    state_d = ST_ACC3;
			ST_ACC3:    state_d = ax_q ? ST_DIFF : ST_ACC1;
			ST_DIFF: begin
				case (mode)
					SM_OFF:   state_d = ST_OUT;
					SM_ADAPT: state_d = ST_AD_CHK;
					SM_AVG:   state_d = ST_AVG;
					default:  state_d = ST_TM_DT;
				endcase
			end
			ST_AD_CHK:  state_d = (ddx_abs >= $signed(TEN_Q) || ddy_abs >= $signed(TEN_Q))
			                      ? ST_AD_K : ST_AD_SQ;
			ST_AD_SQ:   state_d = ST_AD_ACC;
			ST_AD_ACC:  state_d = ax_q ? ST_RT_SQ : ST_AD_SQ;
			ST_RT_SQ:   state_d = ST_RT_CMP;
			ST_RT_CMP:  state_d = (bit_q == 5'd0) ? ST_AD_K : ST_RT_SQ;
			ST_AD_K:    state_d = ST_AD_Q;
			ST_AD_Q:    state_d = ST_AD_AMT;
			ST_AD_AMT:  state_d = ST_BL_MUL;
			ST_AVG:     state_d = ST_OUT;
			ST_TM_DT:   state_d = ST_TM_DTS;
			ST_TM_DTS:  state_d = (dx_q > -32'sd65536 && dx_q < 32'sd65536 &&
			                       dy_q > -32'sd65536 && dy_q < 32'sd65536)
			                      ? ST_TM_SQ : ST_TM_RATE;
			ST_TM_SQ:   state_d = ST_TM_ACC;
			ST_TM_ACC:  state_d = ax_q ? ST_TM_RATE : ST_TM_SQ;
			ST_TM_RATE: state_d = ST_TM_AMT;
			ST_TM_AMT:  state_d = ST_BL_MUL;
			ST_BL_MUL:  state_d = ST_BL_ADD;
			ST_BL_ADD:  state_d = ax_q ? ST_OUT : ST_BL_MUL;
			ST_OUT:     if (load_out) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control, configuration, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= 1'b0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			gain_q      <= '0;
			cap_q       <= 31'd6553600;
			smooth_q    <= '0;
			decel_q     <= '0;
			mirror_q    <= 1'b0;
			prev_dx_q   <= '0;
			prev_dy_q   <= '0;
			scr_x_q     <= X_RST;
			scr_y_q     <= Y_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ACCEL_GAIN:   gain_q   <= cfg_data[21:0];
					CFG_ACCEL_CAP:    cap_q    <= cfg_data[30:0];
					CFG_SMOOTH_VALUE: smooth_q <= cfg_data[21:0];
					CFG_DECEL_VALUE:  decel_q  <= cfg_data[21:0];
					CFG_MIRROR:       mirror_q <= cfg_data[0];
					default: ;
				endcase
			end
			// axis toggle at the end of each per-axis pair
			if (state_q == ST_ACC3 || state_q == ST_AD_ACC || state_q == ST_TM_ACC ||
			    state_q == ST_BL_ADD)
				ax_q <= ~ax_q;
			if (state_q == ST_AD_ACC)
				bit_q <= 5'd19;
			else if (state_q == ST_RT_CMP)
				bit_q <= bit_q - 5'd1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load_out) begin
				scr_x_q     <= nx;
				scr_y_q     <= ny;
				if (mode != SM_OFF) begin
					prev_dx_q <= dx_q;
					prev_dy_q <= dy_q;
				end
			end
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				rx_q   <= in_req.raw_dx;
				ry_q   <= in_req.raw_dy;
				wup_q  <= (in_req.wheel_step > 8'sd0);
				wdn_q  <= in_req.wheel_step[7];
				us_q   <= in_req.frame_time_us;
				menu_q <= in_req.in_menu;
			end
			ST_NOACC: begin
				dx_q <= {rx_q, 16'd0};
				dy_q <= {ry_q, 16'd0};
			end
			ST_ACC3: begin
				if (ax_q)
					dy_q <= acc_val[31:0];
				else
					dx_q <= acc_val[31:0];
			end
			ST_DIFF: begin
				ddx_q <= ddx_n;
				ddy_q <= ddy_n;
			end
			ST_AD_CHK: begin
				s2_q  <= '0;
				len_q <= TEN_Q[19:0];
			end
			ST_AD_ACC: begin
				s2_q   <= s2_q + prod_q[39:0];
				root_q <= '0;
			end
			ST_RT_CMP: begin
				root_q <= root_nxt;
				if (root_nxt > TEN_Q[19:0])
					len_q <= TEN_Q[19:0];
				else
					len_q <= root_nxt;
			end
			ST_AD_AMT: amt_q <= Q_ONE - prod_q[39:23];
			ST_AVG: begin
				dx_q <= avg_x[31:0];
				dy_q <= avg_y[31:0];
			end
			ST_TM_DTS: begin
				dt_q <= prod_q[53:41];
				s2_q <= (dx_q > -32'sd65536 && dx_q < 32'sd65536 &&
				         dy_q > -32'sd65536 && dy_q < 32'sd65536) ? '0 : '1;
			end
			ST_TM_ACC: s2_q <= s2_q + prod_q[39:0];
			ST_TM_AMT: amt_q <= (amt_t > {3'd0, Q_ONE}) ? Q_ONE : amt_t[16:0];
			ST_BL_ADD: begin
				if (ax_q)
					dy_q <= bl_sum[31:0];
				else
					dx_q <= bl_sum[31:0];
			end
			default: ;
		endcase
		if (load_out) begin
			out_q.out_dx     <= ox;
			out_q.out_dy     <= oy;
			out_q.wheel_up   <= wup_q;
			out_q.wheel_down <= wdn_q;
			out_q.x_moved    <= (ox != 32'sd0);
			out_q.y_moved    <= (oy != 32'sd0);
			out_q.cursor_x   <= nx[25:16];
			out_q.cursor_y   <= ny[25:16];
		end
	end

endmodule

>>> sv/mmc_checker.sv
`include "assert_macros.svh"

module mmc_checker import mmc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input mmc_in_t  in_req,
	input logic     out_valid,
	input logic     out_ready,
	input mmc_out_t out_rsp
);

	// a held result keeps its payload
	`MMC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rsp), "result dropped or changed while stalled")

	// the block works on one request at a time
	`MMC_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

	// wheel flags are exclusive
	`MMC_ASSERT(a_wheel, out_valid, !(out_rsp.wheel_up && out_rsp.wheel_down), "both wheel flags set")

	// motion flags follow the deltas
	`MMC_ASSERT(a_moved, out_valid, (out_rsp.x_moved == (out_rsp.out_dx != 0)) && (out_rsp.y_moved == (out_rsp.out_dy != 0)), "motion flag mismatch")

endmodule

bind mouse_motion_conditioner mmc_checker u_mmc_checker (.*);
